// ===== rtl/core/ccmd_pkg.sv =====
`default_nettype none

package ccmd_pkg;

    localparam logic [15:0] HALF_Q15 = 16'd16384;

    // neighbor codes on the 3x3 stencil, row major from south-west
    localparam logic [3:0] DIR_NONE = 4'd0;
    localparam logic [3:0] DIR_SW   = 4'd1;
    localparam logic [3:0] DIR_S    = 4'd2;
    localparam logic [3:0] DIR_SE   = 4'd3;
    localparam logic [3:0] DIR_W    = 4'd4;
    localparam logic [3:0] DIR_E    = 4'd5;
    localparam logic [3:0] DIR_NW   = 4'd6;
    localparam logic [3:0] DIR_N    = 4'd7;
    localparam logic [3:0] DIR_NE   = 4'd8;

    localparam logic [1:0] ERR_OK      = 2'd0;
    localparam logic [1:0] ERR_COVERED = 2'd1;
    localparam logic [1:0] ERR_LOWVOL  = 2'd2;

    typedef struct packed {
        logic [3:0]  edge_blocked;
        logic [63:0] frac_corners;
        logic [63:0] frac_sides;
        logic [15:0] frac_center;
        logic [15:0] aperture_y_high;
        logic [15:0] aperture_y_low;
        logic [15:0] aperture_x_high;
        logic [15:0] aperture_x_low;
    } t_cell_in;

    typedef struct packed {
        logic [1:0] error_code;
        logic [3:0] corner_dir;
        logic [3:0] second_dir;
        logic [3:0] first_dir;
        logic [1:0] merge_count;
        logic       active;
    } t_cell_out;

endpackage

`default_nettype wire

// ===== rtl/core/cut_cell_merge_direction_top.sv =====
// An accepted input beat is held in the input register, then its result in the
// result register.
// Throughput: one beat per cycle while i_out_stall is low; set by the single
// pass of compares and three chained 18-bit adds between the two registers.
// Reset (synchronous, active low) empties both stages and clears prefer_y.
`default_nettype none

module cut_cell_merge_direction_top
    import ccmd_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire        i_cfg_wdata,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  t_cell_in   i_in_data,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output t_cell_out  o_out_data
);

    logic      r_prefer_y;
    logic      r_in_valid;
    t_cell_in  r_in;
    logic      r_out_valid;
    t_cell_out r_out;
    t_cell_out n_out;
    logic      adv;

    function automatic logic [15:0] side_frac(input logic [63:0] s, input logic [3:0] code);
        logic [15:0] f;
        case (code)
            DIR_W:   f = s[15:0];
            DIR_E:   f = s[31:16];
            DIR_S:   f = s[47:32];
            default: f = s[63:48];
        endcase
        return f;
    endfunction

    function automatic logic [15:0] corner_frac(input logic [63:0] c, input logic [3:0] code);
        logic [15:0] f;
        case (code)
            DIR_SW:  f = c[15:0];
            DIR_SE:  f = c[31:16];
            DIR_NW:  f = c[47:32];
            default: f = c[63:48];
        endcase
        return f;
    endfunction

    assign adv        = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prefer_y  <= 1'b0;
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_prefer_y <= i_cfg_wdata;
            end
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
            end
            if (adv) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!o_in_stall) begin
            r_in <= i_in_data;
        end
        if (adv) begin
            r_out <= n_out;
        end
    end

    always_comb begin
        logic signed [16:0] dx;
        logic signed [16:0] dy;
        logic [15:0] ax;
        logic [15:0] ay;
        logic        xm_ok, xp_ok, ym_ok, yp_ok;
        logic        nx_pos, nx_ge, nx_le, ny_pos, ny_ge, ny_le, xpick;
        logic [3:0]  first;
        logic [3:0]  second;
        logic [3:0]  corner;
        logic [15:0] f1;
        logic [17:0] sum;
        logic        x_first;
        logic        east, north;

        dx = $signed({1'b0, r_in.aperture_x_high}) - $signed({1'b0, r_in.aperture_x_low});
        dy = $signed({1'b0, r_in.aperture_y_high}) - $signed({1'b0, r_in.aperture_y_low});
        ax = dx[16] ? 16'(-dx) : dx[15:0];
        ay = dy[16] ? 16'(-dy) : dy[15:0];
        xm_ok = !r_in.edge_blocked[0];
        xp_ok = !r_in.edge_blocked[1];
        ym_ok = !r_in.edge_blocked[2];
        yp_ok = !r_in.edge_blocked[3];
        east  = 1'b0;
        north = 1'b0;

        // the off-axis component is nudged: zero reads as positive, never as a tie
        if (r_prefer_y) begin
            nx_pos = !dx[16];
            nx_ge  = !dx[16];
            nx_le  = dx[16];
            ny_pos = !dy[16] && (dy != '0);
            ny_ge  = !dy[16];
            ny_le  = dy[16] || (dy == '0);
            xpick  = (ax > ay) || (ax == '0 && ay == '0);
        end else begin
            nx_pos = !dx[16] && (dx != '0);
            nx_ge  = !dx[16];
            nx_le  = dx[16] || (dx == '0);
            ny_pos = !dy[16];
            ny_ge  = !dy[16];
            ny_le  = dy[16];
            xpick  = (ax > ay) || (ax == ay && ax != '0);
        end

        if (xpick) begin
            first = nx_pos ? DIR_E : DIR_W;
        end else begin
            first = ny_pos ? DIR_N : DIR_S;
        end
        if ((!xm_ok && first == DIR_W) || (!xp_ok && first == DIR_E)) begin
            first = ny_pos ? DIR_N : DIR_S;
        end
        if ((!ym_ok && first == DIR_S) || (!yp_ok && first == DIR_N)) begin
            first = nx_pos ? DIR_E : DIR_W;
        end
        x_first = (first == DIR_W) || (first == DIR_E);

        f1     = side_frac(r_in.frac_sides, first);
        sum    = 18'(r_in.frac_center) + 18'(f1);
        second = DIR_NONE;
        corner = DIR_NONE;

        n_out = '0;
        if (r_in.frac_center != '0 && r_in.frac_center < HALF_Q15) begin
            n_out.active      = 1'b1;
            n_out.first_dir   = first;
            n_out.merge_count = 2'd1;
            if (f1 == '0) begin
                n_out.error_code = ERR_COVERED;
            end else begin
                if (sum < 18'(HALF_Q15)) begin
                    if (!x_first) begin
                        if (nx_ge && xp_ok) begin
                            second = DIR_E;
                        end else if (nx_le && xm_ok) begin
                            second = DIR_W;
                        end
                    end else begin
                        if (ny_ge && yp_ok) begin
                            second = DIR_N;
                        end else if (ny_le && ym_ok) begin
                            second = DIR_S;
                        end
                    end
                end
                if (second != DIR_NONE) begin
                    east  = (first == DIR_E) || (second == DIR_E);
                    north = (first == DIR_N) || (second == DIR_N);
                    case ({east, north})
                        2'b11:   corner = DIR_NE;
                        2'b01:   corner = DIR_NW;
                        2'b10:   corner = DIR_SE;
                        default: corner = DIR_SW;
                    endcase
                    sum = sum + 18'(side_frac(r_in.frac_sides, second))
                              + 18'(corner_frac(r_in.frac_corners, corner));
                    n_out.merge_count = 2'd3;
                end
                n_out.second_dir = second;
                n_out.corner_dir = corner;
                n_out.error_code = (sum < 18'(HALF_Q15)) ? ERR_LOWVOL : ERR_OK;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

// ===== rtl/core/ccmd_checker.sv =====
`default_nettype none

module ccmd_checker
    import ccmd_pkg::*;
(
    input wire       i_clk,
    input wire       i_rst_n,
    input wire       i_out_stall,
    input wire       o_out_valid,
    input t_cell_out o_out_data
);

    // a held result beat keeps its contents
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result beat changed under stall");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_data.active |-> o_out_data == '0)
        else $error("inactive cell with nonzero fields");

    a_covered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.error_code == ERR_COVERED |->
            o_out_data.merge_count == 2'd1 && o_out_data.second_dir == DIR_NONE
            && o_out_data.corner_dir == DIR_NONE)
        else $error("covered merge claimed extra neighbors");

    a_corner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.active |->
            ((o_out_data.merge_count == 2'd3) == (o_out_data.corner_dir != DIR_NONE))
            && ((o_out_data.merge_count == 2'd3) == (o_out_data.second_dir != DIR_NONE)))
        else $error("merge count disagrees with claimed neighbors");

endmodule

bind cut_cell_merge_direction_top ccmd_checker u_ccmd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_stall (i_out_stall),
    .o_out_valid (o_out_valid),
    .o_out_data  (o_out_data)
);

`default_nettype wire
